FILE: rtl/core/sadc_pkg.sv
// Shared types, constants and codes of the serial ADC frame responder.
package sadc_pkg;

   // Field widths
   localparam int BYTE_W     = 8;
   localparam int CHAN_MV_W  = 14;
   localparam int CHAN_W     = 3;
   localparam int NUM_CHAN   = 8;
   localparam int CODE_W     = 12;
   localparam int CODE_IDX_W = 4;
   localparam int POS_W      = 5;

   // Reference voltage and chip select polarity
   localparam int unsigned VREF_MV         = 5000;
   localparam logic        CS_ACTIVE_LEVEL = 1'b0;

   // Input opcodes
   localparam logic OP_TRANSFER    = 1'b0;
   localparam logic OP_FRAME_RESET = 1'b1;

   // Bit sequencer positions
   localparam logic [POS_W-1:0] POS_START      = 5'd0;
   localparam logic [POS_W-1:0] POS_MODE       = 5'd1;
   localparam logic [POS_W-1:0] POS_CH_HI      = 5'd2;
   localparam logic [POS_W-1:0] POS_CH_LO      = 5'd4;
   localparam logic [POS_W-1:0] POS_IDLE       = 5'd5;
   localparam logic [POS_W-1:0] POS_LATCH      = 5'd6;
   localparam logic [POS_W-1:0] POS_DATA_FIRST = 5'd7;
   localparam logic [POS_W-1:0] POS_DATA_LAST  = 5'd18;

   // Conversion: code = floor(4095 * delta / VREF) done as x * RECIP >> RECIP_SHIFT,
   // exact for x = 4095 * delta below 2**26 and VREF from 513 up to 16383.
   localparam int X_W         = CHAN_MV_W + CODE_W;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 40;
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << RECIP_SHIFT) + VREF_MV - 1) / VREF_MV;
   localparam logic [RECIP_W-1:0]   RECIP     = RECIP_W'(RECIP_FULL);
   localparam logic [CHAN_MV_W-1:0] VREF_CODE = CHAN_MV_W'(VREF_MV);

   // Queue and pipeline sizes
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int BACK_DEPTH  = 4;

   typedef logic [CHAN_MV_W-1:0] chan_mv_type;
   typedef chan_mv_type [1:0] chan_pair_type;
   typedef chan_pair_type [NUM_CHAN/2-1:0] chan_bank_type;

   localparam chan_mv_type CHAN_RESET [NUM_CHAN] = '{
      14'd0, 14'd1000, 14'd2500, 14'd3000, 14'd3300, 14'd4000, 14'd4500, 14'd5000
   };

   // Classified transaction handed from front to back
   typedef struct packed {
      logic                                latch;
      logic                                single_ended;
      logic [CHAN_W-1:0]                   channel;
      logic [BYTE_W-1:0]                   emit;
      logic [BYTE_W-1:0][CODE_IDX_W-1:0]   code_bit;
   } desc_type;

endpackage

FILE: rtl/core/spi_adc_frame_responder_core.sv
// Top level of the serial ADC frame responder: registers, front, queue and back.
//
// Device side of an 8-channel 12-bit serial ADC, one SPI byte per transaction.
// Each req transaction carries a byte, the mask of clocked bit positions and the
// chip select level, or a frame reset (opcode 1) that restarts the bit count.
// Clocked bits run MSB first through start, single/differential, three channel
// bits, an idle bit and a latch bit; then the 12-bit code goes out MSB first.
// Code = floor(4095 * (va - vb) / 5000), clamped to 0..4095, with differential
// pairs (0,1) (2,3) (4,5) (6,7). Every req transaction gives exactly one rsp
// transaction with the masked MISO byte; unselected chip or frame reset gives 0.
// Throughput is one transaction per clock: the front walks all eight bits of a
// byte combinationally and pushes the classified transaction into a 4-entry
// queue. The back is a four-register pipeline (channel pair select and clamp,
// times 4095, reciprocal multiply, output byte); a result passes the queue and
// these registers to reach rsp. Backpressure on rsp stalls the back pipeline;
// req_ready drops only when the queue is full. Channel voltages are written
// through csr (index 0..7, 14-bit millivolts); the user must write them only
// while the block is idle, which it does not enforce. csr_ready is always high.
module spi_adc_frame_responder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_opcode,
   input  logic [sadc_pkg::BYTE_W-1:0]      req_mosi_byte,
   input  logic [sadc_pkg::BYTE_W-1:0]      req_bit_mask,
   input  logic                             req_cs_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [sadc_pkg::BYTE_W-1:0]      rsp_miso_byte,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sadc_pkg::CHAN_W-1:0]      csr_index,
   input  logic [sadc_pkg::CHAN_MV_W-1:0]   csr_data
);
   import sadc_pkg::*;

   chan_bank_type chan_ff;
   logic          q_full, q_push, q_valid, q_pop;
   desc_type      push_desc, head_desc;

   assign csr_ready = 1'b1;

   // channel voltages, stored as pairs so the back reads one row per transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_CHAN / 2; r++) begin
            chan_ff[r][0] <= CHAN_RESET[2 * r];
            chan_ff[r][1] <= CHAN_RESET[2 * r + 1];
         end
      end else if (csr_valid && csr_ready) begin
         chan_ff[csr_index[CHAN_W-1:1]][csr_index[0]] <= csr_data;
      end
   end

   sadc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_mosi_byte (req_mosi_byte),
      .req_bit_mask  (req_bit_mask),
      .req_cs_level  (req_cs_level),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_desc        (push_desc)
   );

   sadc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (push_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (head_desc)
   );

   sadc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .chan_bank     (chan_ff),
      .q_valid       (q_valid),
      .q_desc        (head_desc),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_miso_byte (rsp_miso_byte)
   );

endmodule

FILE: rtl/core/sadc_front.sv
// Front end: accepts SPI byte transactions and walks the bit sequencer.
module sadc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_opcode,
   input  logic [sadc_pkg::BYTE_W-1:0] req_mosi_byte,
   input  logic [sadc_pkg::BYTE_W-1:0] req_bit_mask,
   input  logic                      req_cs_level,
   input  logic                      q_full,
   output logic                      q_push,
   output sadc_pkg::desc_type        q_desc
);
   import sadc_pkg::*;

   logic [POS_W-1:0]  bit_pos_ff, bit_pos_in;
   logic              single_ended_ff, single_ended_in;
   logic [CHAN_W-1:0] chan_sel_ff, chan_sel_in;
   logic [POS_W-1:0]  data_off;
   logic              bit_val;
   desc_type          desc;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;
   assign q_desc    = desc;

   // Up to eight clocked bits, MSB first
   always_comb begin
      bit_pos_in      = bit_pos_ff;
      single_ended_in = single_ended_ff;
      chan_sel_in     = chan_sel_ff;
      desc            = '0;
      data_off        = '0;
      bit_val         = 1'b0;
      if (req_opcode == OP_FRAME_RESET) begin
         bit_pos_in = POS_START;
      end else if (req_cs_level == CS_ACTIVE_LEVEL) begin
         for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (req_bit_mask[i]) begin
               bit_val = req_mosi_byte[i];
               if (bit_pos_in == POS_START) begin
                  if (bit_val) begin
                     bit_pos_in = POS_MODE;
                  end
               end else if (bit_pos_in == POS_MODE) begin
                  single_ended_in = bit_val;
                  chan_sel_in     = '0;
                  bit_pos_in      = POS_CH_HI;
               end else if (bit_pos_in inside {[POS_CH_HI:POS_CH_LO]}) begin
                  chan_sel_in = chan_sel_in | (CHAN_W'(bit_val) << (POS_CH_LO - bit_pos_in));
                  bit_pos_in  = bit_pos_in + POS_W'(1);
               end else if (bit_pos_in == POS_IDLE) begin
                  bit_pos_in = POS_LATCH;
               end else if (bit_pos_in == POS_LATCH) begin
                  desc.latch        = 1'b1;
                  desc.single_ended = single_ended_in;
                  desc.channel      = chan_sel_in;
                  bit_pos_in        = POS_DATA_FIRST;
               end else if (bit_pos_in inside {[POS_DATA_FIRST:POS_DATA_LAST]}) begin
                  data_off         = POS_DATA_LAST - bit_pos_in;
                  desc.emit[i]     = 1'b1;
                  desc.code_bit[i] = data_off[CODE_IDX_W-1:0];
                  bit_pos_in       = bit_pos_in + POS_W'(1);
               end
               // past the last data bit: frame done, nothing moves
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_pos_ff      <= POS_START;
         single_ended_ff <= 1'b0;
         chan_sel_ff     <= '0;
      end else if (q_push) begin
         bit_pos_ff      <= bit_pos_in;
         single_ended_ff <= single_ended_in;
         chan_sel_ff     <= chan_sel_in;
      end
   end

endmodule

FILE: rtl/core/sadc_queue.sv
// Short FIFO of classified transactions between front and back.
module sadc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sadc_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output sadc_pkg::desc_type head_desc
);
   import sadc_pkg::*;

   desc_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

FILE: rtl/core/sadc_back.sv
// Back end: conversion pipeline, sample code register and MISO byte output.
module sadc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sadc_pkg::chan_bank_type       chan_bank,
   input  logic                          q_valid,
   input  sadc_pkg::desc_type            q_desc,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [sadc_pkg::BYTE_W-1:0]   rsp_miso_byte
);
   import sadc_pkg::*;

   localparam int PROD_W = X_W + RECIP_W;

   logic                 en;
   chan_pair_type        row;
   chan_mv_type          va, vb, diff, delta_in;
   logic [X_W-1:0]       x_in;
   logic [PROD_W-1:0]    prod;
   logic [CODE_W-1:0]    code_in, code_eff;
   logic [BYTE_W-1:0]    miso_in;

   logic                 s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   desc_type             s1_desc_ff, s2_desc_ff, s3_desc_ff;
   chan_mv_type          s1_delta_ff;
   logic [X_W-1:0]       s2_x_ff;
   logic [CODE_W-1:0]    s3_code_ff;
   logic [CODE_W-1:0]    sample_code_ff;
   logic [BYTE_W-1:0]    miso_ff;

   // whole pipeline moves while the output slot is free or being taken
   assign en            = !out_v_ff || rsp_ready;
   assign q_pop         = en && q_valid;
   assign rsp_valid     = out_v_ff;
   assign rsp_miso_byte = miso_ff;

   // stage 1: pick the pair, difference, clamp at VREF
   always_comb begin
      row  = chan_bank[q_desc.channel[CHAN_W-1:1]];
      va   = row[q_desc.channel[0]];
      vb   = q_desc.single_ended ? '0 : row[~q_desc.channel[0]];
      diff = va - vb;
      if (va <= vb) begin
         delta_in = '0;
      end else if (diff > VREF_CODE) begin
         delta_in = VREF_CODE;
      end else begin
         delta_in = diff;
      end
   end

   // stage 2: times 4095 as shift and subtract
   assign x_in = (X_W'(s1_delta_ff) << CODE_W) - X_W'(s1_delta_ff);

   // stage 3: divide by VREF through the reciprocal
   assign prod    = PROD_W'(s2_x_ff) * PROD_W'(RECIP);
   assign code_in = prod[RECIP_SHIFT +: CODE_W];

   // output: data bits come from the latest latched code
   always_comb begin
      code_eff = s3_desc_ff.latch ? s3_code_ff : sample_code_ff;
      for (int i = 0; i < BYTE_W; i++) begin
         miso_in[i] = s3_desc_ff.emit[i] & code_eff[s3_desc_ff.code_bit[i]];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_desc_ff  <= q_desc;
         s1_delta_ff <= delta_in;
         s2_desc_ff  <= s1_desc_ff;
         s2_x_ff     <= x_in;
         s3_desc_ff  <= s2_desc_ff;
         s3_code_ff  <= code_in;
         miso_ff     <= miso_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         s3_v_ff        <= 1'b0;
         out_v_ff       <= 1'b0;
         sample_code_ff <= '0;
      end else if (en) begin
         s1_v_ff  <= q_valid;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         out_v_ff <= s3_v_ff;
         if (s3_v_ff && s3_desc_ff.latch) begin
            sample_code_ff <= s3_code_ff;
         end
      end
   end

endmodule

FILE: rtl/core/sadc_checker.sv
// Port-level checks of the serial ADC frame responder, bound to its top level.
module sadc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [sadc_pkg::BYTE_W-1:0]      rsp_miso_byte
);
   import sadc_pkg::*;

   localparam int CAPACITY = QUEUE_DEPTH + BACK_DEPTH;
   localparam int OUT_W    = $clog2(CAPACITY + 1) + 1;

   logic [OUT_W-1:0] outstanding_ff;
   logic             req_acc, rsp_acc;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;

   // transactions taken in but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else if (req_acc && !rsp_acc) begin
         outstanding_ff <= outstanding_ff + OUT_W'(1);
      end else if (rsp_acc && !req_acc) begin
         outstanding_ff <= outstanding_ff - OUT_W'(1);
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_miso_byte))
      else $error("stalled rsp transaction changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != '0)
      else $error("rsp transaction without a pending req transaction");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OUT_W'(CAPACITY))
      else $error("more transactions in flight than the block can hold");

   a_ready_only_busy: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> outstanding_ff != '0)
      else $error("req_ready low while nothing is in flight");

endmodule

bind spi_adc_frame_responder_core sadc_checker u_sadc_checker (.*);

FILE: tb/sv/tb.sv
// Self-checking testbench of the serial ADC frame responder core.
module tb;
   import sadc_pkg::*;

   // Watchdog: cycles without any accepted transaction before the run is abandoned
   localparam int IDLE_LIMIT = 5000;
   // Random transactions per channel-voltage setting, six settings in all
   localparam int ITEMS_PER_SETTING = 250;
   localparam int NUM_SETTINGS = 6;

   typedef struct {
      logic              opcode;
      logic [BYTE_W-1:0] mosi;
      logic [BYTE_W-1:0] mask;
      logic              cs;
   } spi_xfer_type;

   // Receiver stall patterns, each held for a random stretch of cycles
   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_ONE_IN_FOUR, RX_MOSTLY} rx_pattern_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = OP_TRANSFER;
   logic [BYTE_W-1:0]   req_mosi_byte = '0;
   logic [BYTE_W-1:0]   req_bit_mask = '0;
   logic                req_cs_level = CS_ACTIVE_LEVEL;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_miso_byte;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CHAN_W-1:0]   csr_index = '0;
   logic [CHAN_MV_W-1:0] csr_data = '0;

   spi_adc_frame_responder_core dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_mosi_byte (req_mosi_byte),
      .req_bit_mask  (req_bit_mask),
      .req_cs_level  (req_cs_level),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_miso_byte (rsp_miso_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // ADC behavior: bit sequencer state and channel voltages as the host
   // has programmed them.
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]  seq_pos = POS_START;
   logic              sel_single = 1'b0;
   logic [CHAN_W-1:0] sel_channel = '0;
   logic [CODE_W-1:0] held_code = '0;
   chan_mv_type       chan_mv_model [NUM_CHAN];

   // floor(4095 * (va - vb) / VREF), clamped to 0..4095
   function automatic logic [CODE_W-1:0] mv_to_code(input int unsigned va, input int unsigned vb);
      int unsigned delta;
      if (va <= vb) return '0;
      delta = va - vb;
      if (delta > VREF_MV) return {CODE_W{1'b1}};
      return CODE_W'((4095 * delta) / VREF_MV);
   endfunction

   // Walks the clocked bits of one SPI byte MSB first; returns the MISO byte.
   function automatic logic [BYTE_W-1:0] spi_byte_response(
         input logic opcode, input logic [BYTE_W-1:0] mosi, input logic [BYTE_W-1:0] mask,
         input logic cs);
      logic [BYTE_W-1:0] miso;
      logic              b;
      int unsigned       vb;
      int                i;
      miso = '0;
      if (opcode == OP_FRAME_RESET) begin
         seq_pos = POS_START;
         return '0;
      end
      // deselected chip: sequencer frozen, line reads zero
      if (cs != CS_ACTIVE_LEVEL) return '0;
      for (i = BYTE_W - 1; i >= 0; i--) begin
         if (mask[i]) begin
            b = mosi[i];
            if (seq_pos == POS_START) begin
               if (b) seq_pos = POS_MODE;
            end else if (seq_pos == POS_MODE) begin
               sel_single = b;
               sel_channel = '0;
               seq_pos = POS_CH_HI;
            end else if (seq_pos <= POS_CH_LO) begin
               sel_channel = sel_channel | (CHAN_W'(b) << (POS_CH_LO - seq_pos));
               seq_pos = seq_pos + 5'd1;
            end else if (seq_pos == POS_IDLE) begin
               seq_pos = POS_LATCH;
            end else if (seq_pos == POS_LATCH) begin
               // differential partner is the other channel of the pair
               vb = sel_single ? 0 : chan_mv_model[sel_channel ^ 3'd1];
               held_code = mv_to_code(chan_mv_model[sel_channel], vb);
               seq_pos = POS_DATA_FIRST;
            end else if (seq_pos <= POS_DATA_LAST) begin
               miso[i] = held_code[POS_DATA_LAST - seq_pos];
               seq_pos = seq_pos + 5'd1;
            end
            // past the last data bit the frame is done and the position holds
         end
      end
      return miso;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus store and expected MISO bytes
   // ---------------------------------------------------------------------
   spi_xfer_type      mosi_pending_q [$];
   logic [BYTE_W-1:0] miso_expected_q [$];
   int                items_queued = 0;
   int                fail_count = 0;

   function automatic void add_item(input logic op, input logic [BYTE_W-1:0] mosi,
                                    input logic [BYTE_W-1:0] mask, input logic cs);
      spi_xfer_type x;
      x.opcode = op;
      x.mosi = mosi;
      x.mask = mask;
      x.cs = cs;
      mosi_pending_q.push_back(x);
      items_queued++;
   endfunction

   // One host frame: frame reset, leading zeros, start, mode, channel, then
   // tail_bits random bits (idle, latch, data clocks and possibly overrun).
   // Bits are spread over the masked positions of each byte; now and then a
   // deselected transaction is slipped in, which must not disturb the frame.
   function automatic void queue_frame(input int lead, input logic se_flag,
                                       input logic [CHAN_W-1:0] ch, input int tail_bits,
                                       input bit full_mask);
      bit                frame_bits [$];
      logic [BYTE_W-1:0] mosi;
      logic [BYTE_W-1:0] mask;
      int                k;
      add_item(OP_FRAME_RESET, 8'($urandom), 8'($urandom), 1'($urandom));
      repeat (lead) frame_bits.push_back(1'b0);
      frame_bits.push_back(1'b1);
      frame_bits.push_back(se_flag);
      for (k = CHAN_W - 1; k >= 0; k--) frame_bits.push_back(ch[k]);
      repeat (tail_bits) frame_bits.push_back(1'($urandom));
      while (frame_bits.size() != 0) begin
         if ($urandom_range(0, 9) == 0)
            add_item(OP_TRANSFER, 8'($urandom), 8'($urandom), !CS_ACTIVE_LEVEL);
         mask = full_mask ? 8'hFF : 8'($urandom);
         mosi = 8'($urandom);
         for (k = BYTE_W - 1; k >= 0; k--)
            if (mask[k] && frame_bits.size() != 0) mosi[k] = frame_bits.pop_front();
         add_item(OP_TRANSFER, mosi, mask, CS_ACTIVE_LEVEL);
      end
   endfunction

   // Channel voltages for each setting; extremes first, random at the end.
   function automatic chan_mv_type channel_setting(input int setting, input int ch);
      case (setting)
         1: return (ch % 2 == 0) ? {CHAN_MV_W{1'b1}} : '0;
         2: return {CHAN_MV_W{1'b1}};
         3: return '0;
         // around full scale: deltas just under, at and over VREF
         4: return (ch % 2 == 0) ? CHAN_MV_W'(VREF_MV - 1 + $urandom_range(0, 2))
                                 : CHAN_MV_W'($urandom_range(0, 2));
         5: return CHAN_MV_W'($urandom_range(0, 16383));
         default: return CHAN_MV_W'($urandom_range(0, 6000));
      endcase
   endfunction

   // CSR writes, only while the core is idle; model follows each accepted write
   task automatic load_channels(input int setting);
      chan_mv_type mv;
      int          ch;
      @(posedge clock);
      for (ch = 0; ch < NUM_CHAN; ch++) begin
         mv = channel_setting(setting, ch);
         csr_valid <= 1'b1;
         csr_index <= CHAN_W'(ch);
         csr_data <= mv;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         chan_mv_model[ch] = mv;
      end
      csr_valid <= 1'b0;
   endtask

   // Sender holds off until every expected response is back, plus a margin
   task automatic wait_idle();
      @(negedge clock);
      while (mosi_pending_q.size() != 0 || req_valid || miso_expected_q.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps; the item on
   // the bus is predicted at the edge where it is accepted.
   // ---------------------------------------------------------------------
   spi_xfer_type next_xfer;
   int           burst_left = 1;
   int           gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            miso_expected_q.push_back(spi_byte_response(req_opcode, req_mosi_byte,
                                                        req_bit_mask, req_cs_level));
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (mosi_pending_q.size() != 0) begin
               next_xfer = mosi_pending_q.pop_front();
               req_valid <= 1'b1;
               req_opcode <= next_xfer.opcode;
               req_mosi_byte <= next_xfer.mosi;
               req_bit_mask <= next_xfer.mask;
               req_cs_level <= next_xfer.cs;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 5) == 0) begin
                  // long back-to-back stretch
                  burst_left = $urandom_range(100, 300);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 15)
                                                         : $urandom_range(0, 3);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: checks each response transaction against the oldest expected
   // byte; stalls rsp_ready on a pattern that is picked again at random.
   // ---------------------------------------------------------------------
   rx_pattern_type    rx_mode = RX_ALWAYS;
   int                rx_left = 0;
   int unsigned       rx_cycle = 0;
   logic [BYTE_W-1:0] miso_want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (miso_expected_q.size() == 0) begin
               $error("unexpected response: miso_byte %02h", rsp_miso_byte);
               fail_count++;
            end else begin
               miso_want = miso_expected_q.pop_front();
               if (rsp_miso_byte !== miso_want) begin
                  $error("miso_byte mismatch: expected %02h, actual %02h",
                         miso_want, rsp_miso_byte);
                  fail_count++;
               end
            end
         end
         rx_cycle++;
         if (rx_left == 0) begin
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end else begin
            rx_left--;
         end
         case (rx_mode)
            RX_ALWAYS:      rsp_ready <= 1'b1;
            RX_COIN:        rsp_ready <= 1'($urandom);
            RX_ONE_IN_FOUR: rsp_ready <= (rx_cycle % 4 == 0);
            default:        rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Watchdog on lack of progress on any channel
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   int setting;

   initial begin
      foreach (chan_mv_model[i]) chan_mv_model[i] = CHAN_RESET[i];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, channel voltages at their reset values.
      add_item(OP_FRAME_RESET, 8'hFF, 8'hFF, !CS_ACTIVE_LEVEL);
      // byte-aligned frame: 5 zeros, start, single-ended, channel 7 (5000 mV = full scale)
      add_item(OP_TRANSFER, 8'h07, 8'hFF, CS_ACTIVE_LEVEL);
      add_item(OP_TRANSFER, 8'hC0, 8'hFF, CS_ACTIVE_LEVEL);
      // deselected mid-frame: no state change, zero out
      add_item(OP_TRANSFER, 8'hFF, 8'hFF, !CS_ACTIVE_LEVEL);
      add_item(OP_TRANSFER, 8'h00, 8'hFF, CS_ACTIVE_LEVEL);
      // nothing clocked
      add_item(OP_TRANSFER, 8'hFF, 8'h00, CS_ACTIVE_LEVEL);
      // frame done: extra clocks read zero and the position holds
      add_item(OP_TRANSFER, 8'hFF, 8'hFF, CS_ACTIVE_LEVEL);
      add_item(OP_FRAME_RESET, 8'h00, 8'h00, CS_ACTIVE_LEVEL);
      // differential channel 1 against 0 packed into one byte, odd masks after
      add_item(OP_TRANSFER, 8'h8F, 8'hFF, CS_ACTIVE_LEVEL);
      add_item(OP_TRANSFER, 8'h55, 8'hFF, CS_ACTIVE_LEVEL);
      add_item(OP_TRANSFER, 8'hAA, 8'h0F, CS_ACTIVE_LEVEL);
      add_item(OP_TRANSFER, 8'h00, 8'hF0, CS_ACTIVE_LEVEL);
      // differential channel 0: below its partner, clamps to zero
      queue_frame(0, 1'b0, 3'd0, 14, 1'b1);
      // differential channel 7 against 6, and single-ended channel 2 with sparse masks
      queue_frame(3, 1'b0, 3'd7, 16, 1'b1);
      queue_frame(1, 1'b1, 3'd2, 14, 1'b0);
      wait_idle();

      // Random part, one block per channel-voltage setting
      for (setting = 1; setting <= NUM_SETTINGS; setting++) begin
         load_channels(setting);
         @(negedge clock);
         items_queued = 0;
         while (items_queued < ITEMS_PER_SETTING) begin
            if ($urandom_range(0, 9) < 8) begin
               queue_frame($urandom_range(0, 6), 1'($urandom), 3'($urandom),
                           $urandom_range(10, 20), $urandom_range(0, 1) == 0);
            end else begin
               // noise: arbitrary transactions, including stray frame resets
               repeat ($urandom_range(1, 4))
                  add_item(($urandom_range(0, 3) == 0) ? OP_FRAME_RESET : OP_TRANSFER,
                           8'($urandom), 8'($urandom), 1'($urandom));
            end
         end
         wait_idle();
      end

      if (fail_count == 0 && miso_expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/sadc_pkg.sv
rtl/core/sadc_front.sv
rtl/core/sadc_queue.sv
rtl/core/sadc_back.sv
rtl/core/spi_adc_frame_responder_core.sv
rtl/core/sadc_checker.sv
tb/sv/tb.sv
